/* rtl/lrl_pkg.sv */
// ----------------------------------------------------------------------------
// lrl_pkg
// Shared widths, operation and status codes, and controller/datapath types
// for the LRU recency list.
// ----------------------------------------------------------------------------
package lrl_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int INDEX_BITS_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic load_req;
    logic do_search;
    logic do_update;
  } lrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } lrl_stat_t;

endpackage

/* rtl/lrl_ifs.sv */
// ----------------------------------------------------------------------------
// lrl_ifs
// Request and response channels of the LRU recency list.
// ----------------------------------------------------------------------------
interface lrl_req_if;
  logic                         valid;
  logic                         ready;
  logic [lrl_pkg::FUNC_W-1:0]   func;
  logic [lrl_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, func, slot_index, input ready);
  modport sink   (input valid, func, slot_index, output ready);
endinterface

interface lrl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lrl_pkg::SLOT_W-1:0]   lru_slot;
  logic [lrl_pkg::SLOT_W-1:0]   mru_slot;
  logic [lrl_pkg::COUNT_W-1:0]  entry_count;
  logic                         is_empty;
  logic [lrl_pkg::STATUS_W-1:0] status;

  modport source (output valid, lru_slot, mru_slot, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, lru_slot, mru_slot, entry_count, is_empty, status,
                  output ready);
endinterface

/* rtl/lrl_ctrl.sv */
// ----------------------------------------------------------------------------
// lrl_ctrl
// Sequencer: accept, search, update. A new request is taken in the update
// cycle so that requests run back to back while the result register is free.
// ----------------------------------------------------------------------------
module lrl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrl_pkg::lrl_stat_t stat,
  output lrl_pkg::lrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    in_ready      = 1'b0;
    cmd.do_search = 1'b0;
    cmd.do_update = 1'b0;
    state_nxt     = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.do_search = 1'b1;
        state_nxt     = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.do_update = 1'b1;
          in_ready      = 1'b1;
          state_nxt     = in_valid ? S_SEARCH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.load_req = in_valid & in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lrl_dpath.sv */
// ----------------------------------------------------------------------------
// lrl_dpath
// Recency list storage, parallel match search, shift update and the
// registered result.
// ----------------------------------------------------------------------------
module lrl_dpath #(
  parameter int DEPTH      = lrl_pkg::DEPTH_DEF,
  parameter int INDEX_BITS = lrl_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lrl_pkg::lrl_cmd_t              cmd,
  output lrl_pkg::lrl_stat_t             stat,
  input  logic [lrl_pkg::FUNC_W-1:0]     in_func,
  input  logic [lrl_pkg::SLOT_W-1:0]     in_slot_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lrl_pkg::SLOT_W-1:0]     out_lru_slot,
  output logic [lrl_pkg::SLOT_W-1:0]     out_mru_slot,
  output logic [lrl_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_is_empty,
  output logic [lrl_pkg::STATUS_W-1:0]   out_status
);

  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = lrl_pkg::SLOT_W;
  localparam int CW    = lrl_pkg::COUNT_W;

  // request
  logic [lrl_pkg::FUNC_W-1:0]   func_r;
  logic [INDEX_BITS-1:0]        val_r;
  logic [SW+INDEX_BITS-1:0]     in_ext;

  // list
  logic [INDEX_BITS-1:0]        entry_r   [DEPTH];
  logic [INDEX_BITS-1:0]        entry_nxt [DEPTH];
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;

  // search results
  logic                         found_r;
  logic [POS_W-1:0]             pos_r;
  logic [INDEX_BITS-1:0]        last_r;
  logic [INDEX_BITS-1:0]        pen_r;
  logic [lrl_pkg::STATUS_W-1:0] status_r;
  logic                         match_found;
  logic [POS_W-1:0]             match_pos;
  logic [INDEX_BITS-1:0]        last_sel;
  logic [INDEX_BITS-1:0]        pen_sel;
  logic [lrl_pkg::STATUS_W-1:0] status_sel;

  // update
  logic                         ok_add;
  logic                         ok_touch;
  logic                         ok_rem;
  logic                         pos_is_last;
  logic [INDEX_BITS-1:0]        lru_val;
  logic [INDEX_BITS-1:0]        lru_out;
  logic [INDEX_BITS-1:0]        mru_out;
  logic [SW+INDEX_BITS-1:0]     lru_ext;
  logic [SW+INDEX_BITS-1:0]     mru_ext;
  logic [CW+CNT_W-1:0]          cnt_ext;

  // result register
  logic                         out_valid_r;
  logic [SW-1:0]                lru_slot_r;
  logic [SW-1:0]                mru_slot_r;
  logic [CW-1:0]                entry_count_r;
  logic                         is_empty_r;
  logic [lrl_pkg::STATUS_W-1:0] out_status_r;

  assign in_ext = {{INDEX_BITS{1'b0}}, in_slot_index};

  // Search: lowest matching position among held entries, plus the entries
  // at the tail and next to the tail.
  always_comb begin
    match_found = 1'b0;
    match_pos   = '0;
    last_sel    = '0;
    pen_sel     = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (entry_r[i] == val_r && CNT_W'(i) < count_r) begin
        match_found = 1'b1;
        match_pos   = POS_W'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if ((CNT_W + 1)'(i + 1) == {1'b0, count_r}) begin
        last_sel = last_sel | entry_r[i];
      end
      if ((CNT_W + 1)'(i + 2) == {1'b0, count_r}) begin
        pen_sel = pen_sel | entry_r[i];
      end
    end
    case (func_r)
      lrl_pkg::FUNC_ADD: begin
        status_sel = (count_r == CNT_W'(DEPTH)) ? lrl_pkg::ST_FULL : lrl_pkg::ST_OK;
      end
      lrl_pkg::FUNC_TOUCH, lrl_pkg::FUNC_REMOVE: begin
        status_sel = match_found ? lrl_pkg::ST_OK : lrl_pkg::ST_ABSENT;
      end
      default: begin
        status_sel = lrl_pkg::ST_OK;
      end
    endcase
  end

  // Update: shift lanes towards the tail on add or touch, towards the head
  // on remove.
  always_comb begin
    ok_add      = (func_r == lrl_pkg::FUNC_ADD) && (count_r != CNT_W'(DEPTH));
    ok_touch    = (func_r == lrl_pkg::FUNC_TOUCH) && found_r;
    ok_rem      = (func_r == lrl_pkg::FUNC_REMOVE) && found_r;
    pos_is_last = (CNT_W'(pos_r) == count_r - CNT_W'(1));

    for (int i = 0; i < DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
    end
    if (ok_add || ok_touch) begin
      entry_nxt[0] = val_r;
    end
    for (int i = 1; i < DEPTH; i++) begin
      if (ok_add || (ok_touch && POS_W'(i) <= pos_r)) begin
        entry_nxt[i] = entry_r[i-1];
      end
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (ok_rem && POS_W'(i) >= pos_r) begin
        entry_nxt[i] = entry_r[i+1];
      end
    end

    count_nxt = count_r;
    if (ok_add) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ok_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end

    lru_val = last_r;
    if (ok_add && count_r == '0) begin
      lru_val = val_r;
    end else if (ok_touch && pos_is_last) begin
      lru_val = (count_r == CNT_W'(1)) ? val_r : pen_r;
    end else if (ok_rem && pos_is_last) begin
      lru_val = pen_r;
    end

    if (count_nxt == '0) begin
      lru_out = '0;
      mru_out = '0;
    end else begin
      lru_out = lru_val;
      mru_out = entry_nxt[0];
    end
  end

  assign lru_ext = {{SW{1'b0}}, lru_out};
  assign mru_ext = {{SW{1'b0}}, mru_out};
  assign cnt_ext = {{CW{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r <= in_func;
      val_r  <= in_ext[INDEX_BITS-1:0];
    end
    if (cmd.do_search) begin
      found_r  <= match_found;
      pos_r    <= match_pos;
      last_r   <= last_sel;
      pen_r    <= pen_sel;
      status_r <= status_sel;
    end
    if (cmd.do_update) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry_r[i] <= entry_nxt[i];
      end
      lru_slot_r    <= lru_ext[SW-1:0];
      mru_slot_r    <= mru_ext[SW-1:0];
      entry_count_r <= cnt_ext[CW-1:0];
      is_empty_r    <= (count_nxt == '0);
      out_status_r  <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_update) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_lru_slot    = lru_slot_r;
  assign out_mru_slot    = mru_slot_r;
  assign out_entry_count = entry_count_r;
  assign out_is_empty    = is_empty_r;
  assign out_status      = out_status_r;

endmodule

/* rtl/lru_recency_list_unit.sv */
// ----------------------------------------------------------------------------
// lru_recency_list_unit
// Recency-ordered list of cache slot indices for LRU victim selection.
// ----------------------------------------------------------------------------
// A request passes through the request register, the search result registers
// and the result register. The next request is taken in the update cycle of
// the one before, so the request rate is set by the update of the order list.
// A stalled result holds the update cycle until the result register frees.
// Reset clears the entry count and the result valid; list contents are not
// cleared and only entries below the count are ever matched or reported.
module lru_recency_list_unit #(
  parameter int DEPTH      = lrl_pkg::DEPTH_DEF,
  parameter int INDEX_BITS = lrl_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lrl_req_if.sink     in_chan,
  lrl_rsp_if.source   out_chan
);

  lrl_pkg::lrl_cmd_t  cmd;
  lrl_pkg::lrl_stat_t stat;

  lrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrl_dpath #(
    .DEPTH      (DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_chan.func),
    .in_slot_index   (in_chan.slot_index),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_lru_slot    (out_chan.lru_slot),
    .out_mru_slot    (out_chan.mru_slot),
    .out_entry_count (out_chan.entry_count),
    .out_is_empty    (out_chan.is_empty),
    .out_status      (out_chan.status)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU recency list. A queue of requests, directed
// corner cases first and then random bursts that fill, churn and drain the
// list, feeds a clocked driver. A scoreboard model of the recency order
// predicts every response, and the monitor checks each one field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = lrl_pkg::DEPTH_DEF;
  localparam int SW    = lrl_pkg::SLOT_W;
  localparam int CW    = lrl_pkg::COUNT_W;
  localparam int FW    = lrl_pkg::FUNC_W;
  localparam int STW   = lrl_pkg::STATUS_W;

  localparam logic [FW-1:0] FUNC_NOP    = 2'd3;
  localparam int            RAND_ITEMS  = 500;
  localparam int            HOLD_CYCLES = 60;

  localparam int MODE_FILL    = 0;
  localparam int MODE_DRAIN   = 1;
  localparam int MODE_BALANCE = 2;

  typedef struct {
    logic [FW-1:0] func;
    logic [SW-1:0] slot_index;
  } lru_request_t;

  typedef struct packed {
    logic [SW-1:0]  lru_slot;
    logic [SW-1:0]  mru_slot;
    logic [CW-1:0]  entry_count;
    logic           is_empty;
    logic [STW-1:0] status;
  } lru_result_t;

  logic clk;
  logic rst_n;

  lrl_req_if req_if ();
  lrl_rsp_if rsp_if ();

  lru_recency_list_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  lru_request_t  pending_requests[$];
  lru_result_t   expected_results[$];
  logic [SW-1:0] recency_order[DEPTH];
  int            held_n;
  int            error_count;

  // Model of the order list: position 0 is the most recent entry.
  function automatic lru_result_t lru_predict_request(logic [FW-1:0] fn,
                                                      logic [SW-1:0] idx);
    lru_result_t r;
    int          pos;
    r.status = lrl_pkg::ST_OK;
    pos      = -1;
    if (fn == lrl_pkg::FUNC_ADD) begin
      if (held_n >= DEPTH) begin
        r.status = lrl_pkg::ST_FULL;
      end else begin
        for (int i = held_n; i > 0; i--) recency_order[i] = recency_order[i-1];
        recency_order[0] = idx;
        held_n++;
      end
    end else if (fn == lrl_pkg::FUNC_TOUCH || fn == lrl_pkg::FUNC_REMOVE) begin
      // scan from the back so the most recent match wins
      for (int i = held_n - 1; i >= 0; i--) begin
        if (recency_order[i] == idx) pos = i;
      end
      if (pos < 0) begin
        r.status = lrl_pkg::ST_ABSENT;
      end else if (fn == lrl_pkg::FUNC_TOUCH) begin
        for (int i = pos; i > 0; i--) recency_order[i] = recency_order[i-1];
        recency_order[0] = idx;
      end else begin
        for (int i = pos; i + 1 < held_n; i++) recency_order[i] = recency_order[i+1];
        held_n--;
      end
    end
    r.lru_slot    = (held_n == 0) ? '0 : recency_order[held_n-1];
    r.mru_slot    = (held_n == 0) ? '0 : recency_order[0];
    r.entry_count = CW'(held_n);
    r.is_empty    = (held_n == 0);
    return r;
  endfunction

  task automatic queue_request(logic [FW-1:0] fn, logic [SW-1:0] idx);
    lru_request_t t;
    t.func       = fn;
    t.slot_index = idx;
    pending_requests.push_back(t);
  endtask

  // Driver: a random idle gap drawn per transfer, none in a middle stretch.
  int           send_gap;
  int           gap_draw;
  int           sent_n;
  lru_request_t drv_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      send_gap     <= 0;
      sent_n       <= 0;
    end else if (req_if.valid && req_if.ready) begin
      expected_results.push_back(lru_predict_request(req_if.func, req_if.slot_index));
      sent_n <= sent_n + 1;
      if (sent_n >= 300 && sent_n < 360) gap_draw = 0;
      else gap_draw = $urandom_range(0, 3);
      send_gap <= gap_draw;
      if (gap_draw == 0 && pending_requests.size() != 0) begin
        drv_next          = pending_requests.pop_front();
        req_if.func       <= drv_next.func;
        req_if.slot_index <= drv_next.slot_index;
      end else begin
        req_if.valid <= 1'b0;
      end
    end else if (!req_if.valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_requests.size() != 0) begin
        drv_next          = pending_requests.pop_front();
        req_if.func       <= drv_next.func;
        req_if.slot_index <= drv_next.slot_index;
        req_if.valid      <= 1'b1;
      end
    end
  end

  // Monitor: a random stall drawn per transfer, one long hold to back up the block.
  int          rcv_stall;
  int          stall_draw;
  int          rcv_n;
  lru_result_t seen;
  lru_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rcv_stall    <= 0;
      rcv_n        <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      seen.lru_slot    = rsp_if.lru_slot;
      seen.mru_slot    = rsp_if.mru_slot;
      seen.entry_count = rsp_if.entry_count;
      seen.is_empty    = rsp_if.is_empty;
      seen.status      = rsp_if.status;
      if (expected_results.size() == 0) begin
        $display("%0t: response with none expected: lru %0d mru %0d count %0d",
                 $time, seen.lru_slot, seen.mru_slot, seen.entry_count);
        $display("%0t: unexpected response: empty %0d status %0d",
                 $time, seen.is_empty, seen.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (seen.lru_slot !== want.lru_slot) begin
          $display("%0t: lru_slot expected %0d actual %0d", $time, want.lru_slot,
                   seen.lru_slot);
          error_count++;
        end
        if (seen.mru_slot !== want.mru_slot) begin
          $display("%0t: mru_slot expected %0d actual %0d", $time, want.mru_slot,
                   seen.mru_slot);
          error_count++;
        end
        if (seen.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   seen.entry_count);
          error_count++;
        end
        if (seen.is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %0d actual %0d", $time, want.is_empty,
                   seen.is_empty);
          error_count++;
        end
        if (seen.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, seen.status);
          error_count++;
        end
      end
      rcv_n <= rcv_n + 1;
      if (rcv_n == 150) stall_draw = HOLD_CYCLES;
      else if (rcv_n >= 300 && rcv_n < 360) stall_draw = 0;
      else stall_draw = $urandom_range(0, 3);
      rcv_stall <= stall_draw;
      if (stall_draw != 0) rsp_if.ready <= 1'b0;
    end else if (!rsp_if.ready) begin
      if (rcv_stall > 0) rcv_stall <= rcv_stall - 1;
      else rsp_if.ready <= 1'b1;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [SW-1:0] pool[8];
    int            counted;
    int            mode;
    int            roll;
    logic [FW-1:0] fn;
    logic [SW-1:0] idx;

    rst_n       = 1'b0;
    error_count = 0;
    held_n      = 0;

    // empty list: absent index, idle code
    queue_request(lrl_pkg::FUNC_REMOVE, 8'd5);
    queue_request(lrl_pkg::FUNC_TOUCH, 8'd5);
    queue_request(FUNC_NOP, 8'hFF);
    // two entries, drop the front one, then the last one
    queue_request(lrl_pkg::FUNC_ADD, 8'h10);
    queue_request(lrl_pkg::FUNC_ADD, 8'h20);
    queue_request(lrl_pkg::FUNC_REMOVE, 8'h20);
    queue_request(lrl_pkg::FUNC_REMOVE, 8'h10);
    // extremes and alternating bit patterns
    queue_request(lrl_pkg::FUNC_ADD, 8'h00);
    queue_request(lrl_pkg::FUNC_ADD, 8'hFF);
    queue_request(lrl_pkg::FUNC_ADD, 8'hAA);
    queue_request(lrl_pkg::FUNC_ADD, 8'h55);
    queue_request(lrl_pkg::FUNC_TOUCH, 8'h00);
    queue_request(lrl_pkg::FUNC_TOUCH, 8'h00);
    // duplicate: remove takes the most recent copy
    queue_request(lrl_pkg::FUNC_ADD, 8'hFF);
    queue_request(lrl_pkg::FUNC_REMOVE, 8'hFF);
    queue_request(lrl_pkg::FUNC_TOUCH, 8'h77);
    queue_request(FUNC_NOP, 8'h00);
    // fill up and add once more while full
    for (int i = 0; i < DEPTH - 4; i++) queue_request(lrl_pkg::FUNC_ADD, SW'(8'h30 + i));
    queue_request(lrl_pkg::FUNC_ADD, 8'hEE);

    // random bursts over a small pool of indices so touches and removes hit
    counted = 0;
    while (counted < RAND_ITEMS) begin
      mode = $urandom_range(MODE_FILL, MODE_BALANCE);
      foreach (pool[k]) pool[k] = SW'($urandom_range(0, 255));
      for (int j = 0; j < 20; j++) begin
        roll = $urandom_range(0, 99);
        if (mode == MODE_FILL) begin
          fn = (roll < 65) ? lrl_pkg::FUNC_ADD :
               (roll < 80) ? lrl_pkg::FUNC_TOUCH : lrl_pkg::FUNC_REMOVE;
        end else if (mode == MODE_DRAIN) begin
          fn = (roll < 20) ? lrl_pkg::FUNC_ADD :
               (roll < 40) ? lrl_pkg::FUNC_TOUCH : lrl_pkg::FUNC_REMOVE;
        end else begin
          fn = (roll < 40) ? lrl_pkg::FUNC_ADD :
               (roll < 70) ? lrl_pkg::FUNC_TOUCH : lrl_pkg::FUNC_REMOVE;
        end
        if ($urandom_range(0, 4) == 0) idx = SW'($urandom_range(0, 255));
        else idx = pool[$urandom_range(0, 7)];
        // occasional idle code as noise
        if ($urandom_range(0, 32) == 0) fn = FUNC_NOP;
        else counted++;
        queue_request(fn, idx);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || req_if.valid !== 1'b0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
